// ----- src/icy_pkg.sv -----
// ============================================================================
// icy_pkg
// Shared types, constants and the title prefix table of the ICY demux.
// ============================================================================
package icy_pkg;

    localparam int TITLE_CAP   = 64;
    localparam int TITLE_DEPTH = TITLE_CAP - 1;
    localparam int LEN_W       = $clog2(TITLE_CAP);
    localparam int ADDR_W      = (TITLE_DEPTH > 1) ? $clog2(TITLE_DEPTH) : 1;

    localparam int INTERVAL_W  = 20;
    localparam int META_W      = 12;
    localparam int BYTE_W      = 8;
    localparam int PM_W        = 4;

    localparam logic [PM_W-1:0]   PREFIX_LEN = 4'd13;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_AUDIO,
        ST_LEN,
        ST_META,
        ST_BURST
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SR_PREFIX,
        SR_TITLE,
        SR_FOUND,
        SR_DEAD
    } search_phase_t;

    typedef struct packed {
        logic pass_audio;
        logic count_audio;
        logic clear_audio;
        logic load_len;
        logic scan_meta;
        logic rd_start;
        logic emit_title;
    } icy_cmd_t;

    typedef struct packed {
        logic interval_zero;
        logic audio_done;
        logic len_zero;
        logic meta_end;
        logic title_ready;
        logic burst_last;
        logic out_free;
    } icy_status_t;

    // "StreamTitle='"
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [PM_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h72;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h54;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h6C;
            4'd10:   c = 8'h65;
            4'd11:   c = 8'h3D;
            4'd12:   c = 8'h27;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- src/icy_ram.sv -----
// ============================================================================
// icy_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module icy_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/icy_ctrl.sv -----
// ============================================================================
// icy_ctrl
// Stream phase controller: audio, length byte, metadata and title burst.
// ============================================================================
module icy_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  icy_pkg::icy_status_t status,
    output icy_pkg::icy_cmd_t    cmd
);
    import icy_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_AUDIO;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg != ST_BURST) && status.out_free;
        accept     = s_tvalid && s_tready;
        case (state_reg)
            ST_AUDIO: begin
                if (accept) begin
                    cmd.pass_audio = 1'b1;
                    if (status.interval_zero) begin
                        cmd.clear_audio = 1'b1;
                    end else begin
                        cmd.count_audio = 1'b1;
                        if (status.audio_done) begin
                            state_next = ST_LEN;
                        end
                    end
                end
            end
            ST_LEN: begin
                if (accept) begin
                    if (status.interval_zero) begin
                        cmd.pass_audio  = 1'b1;
                        cmd.clear_audio = 1'b1;
                        state_next      = ST_AUDIO;
                    end else if (status.len_zero) begin
                        cmd.clear_audio = 1'b1;
                        state_next      = ST_AUDIO;
                    end else begin
                        cmd.load_len = 1'b1;
                        state_next   = ST_META;
                    end
                end
            end
            ST_META: begin
                if (accept) begin
                    if (status.interval_zero) begin
                        cmd.pass_audio  = 1'b1;
                        cmd.clear_audio = 1'b1;
                        state_next      = ST_AUDIO;
                    end else begin
                        cmd.scan_meta = 1'b1;
                        if (status.meta_end) begin
                            cmd.clear_audio = 1'b1;
                            if (status.title_ready) begin
                                cmd.rd_start = 1'b1;
                                state_next   = ST_BURST;
                            end else begin
                                state_next = ST_AUDIO;
                            end
                        end
                    end
                end
            end
            ST_BURST: begin
                if (status.out_free) begin
                    cmd.emit_title = 1'b1;
                    if (status.burst_last) begin
                        state_next = ST_AUDIO;
                    end
                end
            end
            default: begin
                state_next = ST_AUDIO;
            end
        endcase
    end

    a_burst_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BURST) |-> ($past(state_reg) == ST_BURST || $past(cmd.rd_start)))
        else $error("burst entered without a title read");

    a_burst_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BURST && cmd.emit_title && status.burst_last)
            |=> (state_reg == ST_AUDIO))
        else $error("burst did not end after last title byte");

    a_scan_only_meta: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_meta |-> (state_reg == ST_META && s_tvalid))
        else $error("metadata scan outside metadata phase");

endmodule

// ----- src/icy_dp.sv -----
// ============================================================================
// icy_dp
// Datapath: interval register, counters, title scanner, title store and
// output register.
// ============================================================================
module icy_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [icy_pkg::INTERVAL_W-1:0] cfg_wdata,
    input  logic [icy_pkg::BYTE_W-1:0]     in_byte,
    input  icy_pkg::icy_cmd_t              cmd,
    output icy_pkg::icy_status_t           status,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [icy_pkg::BYTE_W-1:0]     m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import icy_pkg::*;

    localparam logic [LEN_W-1:0] TITLE_MAX = LEN_W'(TITLE_DEPTH);

    logic [INTERVAL_W-1:0] interval_reg;
    logic [INTERVAL_W-1:0] audio_count_reg, audio_count_next, audio_sum;
    logic [META_W-1:0]     meta_left_reg, meta_left_next;
    logic [PM_W-1:0]       pm_reg, pm_next;
    search_phase_t         search_reg, search_next;
    logic                  quote_reg, quote_next;
    logic [LEN_W-1:0]      len_reg, len_next, len1;
    logic [LEN_W-1:0]      rd_idx_reg, rd_idx_next, rd_idx_inc;

    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [BYTE_W-1:0]     ram_rdata;

    logic                  out_valid_reg, out_kind_reg, out_last_reg;
    logic [BYTE_W-1:0]     out_byte_reg;

    assign audio_sum  = audio_count_reg + INTERVAL_W'(1);
    assign rd_idx_inc = rd_idx_reg + LEN_W'(1);

    // title scanner
    always_comb begin
        pm_next     = pm_reg;
        search_next = search_reg;
        quote_next  = quote_reg;
        len_next    = len_reg;
        len1        = len_reg;
        ram_we      = 1'b0;
        if (cmd.load_len) begin
            pm_next     = '0;
            search_next = SR_PREFIX;
            quote_next  = 1'b0;
            len_next    = '0;
        end else if (cmd.scan_meta) begin
            case (search_reg)
                SR_PREFIX: begin
                    if (in_byte == CHAR_NUL) begin
                        search_next = SR_DEAD;
                    end else if (pm_reg < PREFIX_LEN && in_byte == prefix_char(pm_reg)) begin
                        pm_next = pm_reg + PM_W'(1);
                        if (pm_next == PREFIX_LEN) begin
                            search_next = SR_TITLE;
                            quote_next  = 1'b0;
                            len_next    = '0;
                        end
                    end else begin
                        pm_next = (in_byte == CHAR_S) ? PM_W'(1) : PM_W'(0);
                    end
                end
                SR_TITLE: begin
                    if (in_byte == CHAR_NUL) begin
                        search_next = SR_DEAD;
                    end else if (quote_reg && in_byte == CHAR_SEMI) begin
                        search_next = SR_FOUND;
                    end else begin
                        // a pending quote was already written at len_reg
                        if (quote_reg && len_reg < TITLE_MAX) begin
                            len1 = len_reg + LEN_W'(1);
                        end
                        ram_we     = (len1 < TITLE_MAX);
                        quote_next = (in_byte == CHAR_QUOTE);
                        len_next   = len1;
                        if (in_byte != CHAR_QUOTE && len1 < TITLE_MAX) begin
                            len_next = len1 + LEN_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // counters and burst read index
    always_comb begin
        audio_count_next = audio_count_reg;
        meta_left_next   = meta_left_reg;
        rd_idx_next      = rd_idx_reg;
        ram_re           = 1'b0;
        ram_raddr        = '0;
        if (cmd.clear_audio) begin
            audio_count_next = '0;
        end else if (cmd.count_audio) begin
            audio_count_next = status.audio_done ? INTERVAL_W'(0) : audio_sum;
        end
        if (cmd.load_len) begin
            meta_left_next = {in_byte, 4'b0000};
        end else if (cmd.scan_meta) begin
            meta_left_next = meta_left_reg - META_W'(1);
        end
        if (cmd.rd_start) begin
            ram_re      = 1'b1;
            rd_idx_next = '0;
        end else if (cmd.emit_title && !status.burst_last) begin
            ram_re      = 1'b1;
            ram_raddr   = rd_idx_inc[ADDR_W-1:0];
            rd_idx_next = rd_idx_inc;
        end
    end

    always_comb begin
        status.interval_zero = (interval_reg == '0);
        status.audio_done    = (audio_sum >= interval_reg);
        status.len_zero      = (in_byte == CHAR_NUL);
        status.meta_end      = (meta_left_reg == META_W'(1));
        status.title_ready   = (search_next == SR_FOUND) && (len_next != '0);
        status.burst_last    = (rd_idx_inc == len_reg);
        status.out_free      = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg    <= '0;
            audio_count_reg <= '0;
            meta_left_reg   <= '0;
            pm_reg          <= '0;
            search_reg      <= SR_PREFIX;
            quote_reg       <= 1'b0;
            len_reg         <= '0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                interval_reg <= cfg_wdata;
            end
            audio_count_reg <= audio_count_next;
            meta_left_reg   <= meta_left_next;
            pm_reg          <= pm_next;
            search_reg      <= search_next;
            quote_reg       <= quote_next;
            len_reg         <= len_next;
            rd_idx_reg      <= rd_idx_next;
            if (cmd.pass_audio || cmd.emit_title) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pass_audio) begin
            out_kind_reg <= 1'b0;
            out_byte_reg <= in_byte;
            out_last_reg <= 1'b1;
        end else if (cmd.emit_title) begin
            out_kind_reg <= 1'b1;
            out_byte_reg <= ram_rdata;
            out_last_reg <= status.burst_last;
        end
    end

    icy_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TITLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_title_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(len1[ADDR_W-1:0]),
        .wdata(in_byte),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= TITLE_MAX)
        else $error("title length beyond capacity");

    a_prefix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pm_reg <= PREFIX_LEN)
        else $error("prefix match count out of range");

    a_meta_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_meta |-> (meta_left_reg != '0))
        else $error("metadata byte scanned with no bytes due");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("title store written during burst read");

endmodule

// ----- src/icy_metadata_demux.sv -----
// ============================================================================
// icy_metadata_demux
// ICY metadata stripper: passes audio bytes, drops metadata, emits the
// stream title of each metadata block as a tlast-terminated burst.
// ============================================================================
// Audio path: an audio byte appears on m_ in the cycle after its transaction.
// Throughput: one input byte per cycle while the output register drains.
// A title burst follows the last metadata byte and holds s_tready low until its
// last byte enters the output register, also while m_tready holds that register.
// Reset: synchronous, active low; clears interval, counters and scanner state.
// The title store is not cleared; only bytes written in the current block are read.
module icy_metadata_demux (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [icy_pkg::INTERVAL_W-1:0] cfg_wdata,   // metadata_interval
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [icy_pkg::BYTE_W-1:0]     s_tdata,     // [7:0] in_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [icy_pkg::BYTE_W-1:0]     m_tdata,     // [7:0] out_byte
    output logic                           m_tuser,     // [0] out_kind
    output logic                           m_tlast
);
    import icy_pkg::*;

    icy_cmd_t    cmd;
    icy_status_t status;

    icy_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    icy_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
